### sv/mbps_pkg.sv
// package for the masked byte pattern search block
// sizes, register indexes and the types shared by the window chain and the top level
// no dependencies
`default_nettype none

package mbps_pkg;

   // sizes of the block
   localparam int PATTERN_BYTES = 16;   // cells in the window chain
   localparam int ADDRESS_BITS  = 24;   // byte counter and address width

   // the pattern registers hold sixteen bytes; positions above are wildcards
   localparam int PATTERN_REG_BYTES = 16;
   localparam int REG_IDX_W         = $clog2(PATTERN_REG_BYTES);
   localparam int LEN_W             = $clog2(PATTERN_BYTES + 1);
   localparam int LEN_RAW_W         = 5;
   localparam int LEN_CMP_W         = (LEN_W > LEN_RAW_W) ? LEN_W : LEN_RAW_W;

   // fixed field widths
   localparam int BYTE_W   = 8;
   localparam int FIELD_W  = 24;
   localparam int OFFSET_W = 24;
   localparam int CSR_W    = 64;
   localparam int CSR_IDX_W = 3;
   localparam int RSP_DATA_W = 2 * FIELD_W;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_CARE_MASK    = 3'd2,
      CSR_PATTERN_LEN  = 3'd3,
      CSR_PATCH_OFFSET = 3'd4
   } csr_index_type;

   // pattern setup seen by the window chain
   typedef struct packed {
      logic [PATTERN_REG_BYTES-1:0][BYTE_W-1:0] pattern;
      logic [PATTERN_REG_BYTES-1:0]             care;
      logic [LEN_W-1:0]                         len;      // effective length, 1 to max
   } cfg_type;

   // compare setup of one cell
   typedef struct packed {
      logic              active;   // cell lies inside the pattern and is cared
      logic [BYTE_W-1:0] want;
   } cell_ctl_type;

endpackage

`default_nettype wire

### sv/mbps_cell.sv
// one cell of the byte window chain: holds a byte and compares the byte moving in
// depends on mbps_pkg
`default_nettype none

module mbps_cell (
   input  wire                          clock,
   input  wire                          shift_en,
   input  wire  [mbps_pkg::BYTE_W-1:0]  byte_in,
   input  mbps_pkg::cell_ctl_type       ctl,
   output logic [mbps_pkg::BYTE_W-1:0]  byte_out,
   output logic                         mismatch
);
   import mbps_pkg::*;

   logic [BYTE_W-1:0] held_ff;
   logic [BYTE_W-1:0] held_in;

   assign held_in = shift_en ? byte_in : held_ff;

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   // the compare looks at the byte that lands here on this shift
   assign mismatch = ctl.active && (byte_in != ctl.want);
   assign byte_out = held_ff;

endmodule

`default_nettype wire

### sv/mbps_window.sv
// chain of window cells plus the per-cell pattern alignment for the current length
// depends on mbps_pkg and mbps_cell
`default_nettype none

module mbps_window (
   input  wire                          clock,
   input  wire                          shift_en,
   input  wire  [mbps_pkg::BYTE_W-1:0]  code_byte,
   input  mbps_pkg::cfg_type            cfg,
   output logic                         hit
);
   import mbps_pkg::*;

   localparam int POS_W = (LEN_W > REG_IDX_W) ? LEN_W : REG_IDX_W;

   logic [PATTERN_BYTES:0][BYTE_W-1:0] link;
   logic [PATTERN_BYTES-1:0]           mismatch;

   assign link[0] = code_byte;

   for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_cell
      localparam logic [POS_W-1:0] CELL_J = POS_W'(j);
      logic [POS_W-1:0] len_ext;
      logic [POS_W-1:0] pat_pos;
      cell_ctl_type     ctl;

      // cell j holds the byte j places back, matched against pattern byte len-1-j
      assign len_ext = POS_W'(cfg.len);
      assign pat_pos = len_ext - CELL_J - POS_W'(1);
      assign ctl.active = (CELL_J < len_ext)
                       && (pat_pos < POS_W'(PATTERN_REG_BYTES))
                       && cfg.care[pat_pos[REG_IDX_W-1:0]];
      assign ctl.want   = cfg.pattern[pat_pos[REG_IDX_W-1:0]];

      mbps_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .byte_in  (link[j]),
         .ctl      (ctl),
         .byte_out (link[j+1]),
         .mismatch (mismatch[j])
      );
   end

   assign hit = ~|mismatch;

endmodule

`default_nettype wire

### sv/masked_byte_pattern_search.sv
// masked byte pattern search, top level: config registers, byte counter, match latch, result register
// depends on mbps_pkg, mbps_window and mbps_cell
//
// Scans a stream of code bytes, one byte per word on req, for a pattern of up to sixteen bytes
// with per-byte care bits (a clear bit makes that position a wildcard). The byte window is a
// chain of sixteen cells that shift by one on every accepted byte; each cell compares the byte
// moving into it, so the whole window is checked in the same cycle the byte is taken. The block
// takes one byte per clock cycle with no gaps; the only stall is when a finished result still
// sits in the rsp register and rsp_tready is low. The first start position that matches is
// latched. On the word with req_tlast high, one result word appears on rsp the next cycle:
// found in rsp_tuser, the match position and the patch address (position plus the signed patch
// offset, wrapping at the address width) in rsp_tdata, both zero when nothing was found. The
// byte count and match latch then clear for the next image. The byte count saturates at
// 2^24-1; bytes beyond that are not matched. Write configuration only between images.
`default_nettype none

module masked_byte_pattern_search (
   input  wire                                 clock,
   input  wire                                 reset,
   // code bytes
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [mbps_pkg::BYTE_W-1:0]         req_tdata,    // code_byte [7:0]
   input  wire                                 req_tlast,    // last byte of the image
   // scan results
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [mbps_pkg::RSP_DATA_W-1:0]     rsp_tdata,    // match_position [23:0], patch_address [47:24]
   output logic [0:0]                          rsp_tuser,    // found [0]
   // configuration writes
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [mbps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [mbps_pkg::CSR_W-1:0]          csr_data
);
   import mbps_pkg::*;

   localparam int ADDR_W = ADDRESS_BITS;
   localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

   // configuration registers
   logic [CSR_W-1:0]     pattern_low_ff,  pattern_low_in;
   logic [CSR_W-1:0]     pattern_high_ff, pattern_high_in;
   logic [PATTERN_REG_BYTES-1:0] care_ff, care_in;
   logic [LEN_RAW_W-1:0] len_raw_ff, len_raw_in;
   logic [OFFSET_W-1:0]  offset_ff, offset_in;

   // scan state
   logic [ADDR_W-1:0]    bytes_seen_ff, bytes_seen_in;
   logic                 match_seen_ff, match_seen_in;
   logic [ADDR_W-1:0]    first_start_ff, first_start_in;
   logic [ADDR_W-1:0]    first_patch_ff, first_patch_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [FIELD_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [FIELD_W-1:0]   rsp_patch_ff, rsp_patch_in;

   logic                 req_accept;
   logic                 counting;
   logic                 window_hit;
   logic                 hit_now;
   logic                 enough_bytes;
   logic [LEN_CMP_W-1:0] len_raw_ext;
   logic [LEN_W-1:0]     len_eff;
   logic [ADDR_W-1:0]    len_addr;
   logic [ADDR_W-1:0]    cand_start;
   logic [ADDR_W-1:0]    offset_addr;
   logic [ADDR_W-1:0]    cand_patch;
   logic [ADDR_W-1:0]    final_start;
   logic [ADDR_W-1:0]    final_patch;
   cfg_type              cfg;

   // config port never stalls
   assign csr_ready = 1'b1;

   always_comb begin
      pattern_low_in  = pattern_low_ff;
      pattern_high_in = pattern_high_ff;
      care_in         = care_ff;
      len_raw_in      = len_raw_ff;
      offset_in       = offset_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pattern_low_in  = csr_data;
            CSR_PATTERN_HIGH: pattern_high_in = csr_data;
            CSR_CARE_MASK:    care_in         = csr_data[PATTERN_REG_BYTES-1:0];
            CSR_PATTERN_LEN:  len_raw_in      = csr_data[LEN_RAW_W-1:0];
            CSR_PATCH_OFFSET: offset_in       = csr_data[OFFSET_W-1:0];
            default: ;  // unused indexes are dropped
         endcase
      end
   end

   // effective length: zero acts as one, clamp at the window size
   assign len_raw_ext = LEN_CMP_W'(len_raw_ff);
   always_comb begin
      if (len_raw_ext == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_raw_ext > LEN_CMP_W'(PATTERN_BYTES)) begin
         len_eff = LEN_W'(PATTERN_BYTES);
      end else begin
         len_eff = LEN_W'(len_raw_ext);
      end
   end

   assign cfg.pattern = {pattern_high_ff, pattern_low_ff};
   assign cfg.care    = care_ff;
   assign cfg.len     = len_eff;

   // handshake: a byte is taken unless a result is stuck in the output register
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign counting   = bytes_seen_ff != ADDR_MAX;

   mbps_window u_window (
      .clock     (clock),
      .shift_en  (req_accept && counting),
      .code_byte (req_tdata),
      .cfg       (cfg),
      .hit       (window_hit)
   );

   // start position and patch address if the window matches on this byte
   assign len_addr     = ADDR_W'(len_eff);
   assign enough_bytes = bytes_seen_ff >= (len_addr - ADDR_W'(1));
   assign cand_start   = bytes_seen_ff + ADDR_W'(1) - len_addr;
   assign offset_addr  = ADDR_W'({{ADDR_W{offset_ff[OFFSET_W-1]}}, offset_ff});
   assign cand_patch   = cand_start + offset_addr;
   assign hit_now      = counting && !match_seen_ff && enough_bytes && window_hit;

   assign final_start = match_seen_ff ? first_start_ff : cand_start;
   assign final_patch = match_seen_ff ? first_patch_ff : cand_patch;

   always_comb begin
      bytes_seen_in  = bytes_seen_ff;
      match_seen_in  = match_seen_ff;
      first_start_in = first_start_ff;
      first_patch_in = first_patch_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_found_in   = rsp_found_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_patch_in   = rsp_patch_ff;
      if (req_accept) begin
         if (req_tlast) begin
            // result word, then clear for the next image
            rsp_valid_in   = 1'b1;
            rsp_found_in   = match_seen_ff || hit_now;
            rsp_pos_in     = (match_seen_ff || hit_now) ? FIELD_W'(final_start) : '0;
            rsp_patch_in   = (match_seen_ff || hit_now) ? FIELD_W'(final_patch) : '0;
            bytes_seen_in  = '0;
            match_seen_in  = 1'b0;
            first_start_in = '0;
            first_patch_in = '0;
         end else begin
            if (counting) begin
               bytes_seen_in = bytes_seen_ff + ADDR_W'(1);
            end
            if (hit_now) begin
               match_seen_in  = 1'b1;
               first_start_in = cand_start;
               first_patch_in = cand_patch;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         care_ff         <= '1;
         len_raw_ff      <= LEN_RAW_W'(1);
         offset_ff       <= '0;
         bytes_seen_ff   <= '0;
         match_seen_ff   <= 1'b0;
         first_start_ff  <= '0;
         first_patch_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pattern_low_ff  <= pattern_low_in;
         pattern_high_ff <= pattern_high_in;
         care_ff         <= care_in;
         len_raw_ff      <= len_raw_in;
         offset_ff       <= offset_in;
         bytes_seen_ff   <= bytes_seen_in;
         match_seen_ff   <= match_seen_in;
         first_start_ff  <= first_start_in;
         first_patch_ff  <= first_patch_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload, loaded only with a new result
   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_patch_ff <= rsp_patch_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_patch_ff, rsp_pos_ff};
   assign rsp_tuser[0] = rsp_found_ff;

   // a not-found result carries zero position and address
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> (rsp_pos_ff == '0) && (rsp_patch_ff == '0))
      else $error("not-found result with nonzero fields");

   // the last byte always clears the scan state and raises a result
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> (bytes_seen_ff == '0) && !match_seen_ff && rsp_valid_ff)
      else $error("last byte did not close the scan");

   // a latched match holds its position until the image ends
   a_match_holds: assert property (@(posedge clock) disable iff (reset)
      match_seen_ff && !(req_accept && req_tlast)
      |=> match_seen_ff && $stable(first_start_ff) && $stable(first_patch_ff))
      else $error("latched match changed inside a scan");

   // within an image the byte count never goes backward
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      !(req_accept && req_tlast) |=> bytes_seen_ff >= $past(bytes_seen_ff))
      else $error("byte count went backward");

endmodule

`default_nettype wire

### tb/tb_top.sv
// self-checking bench for masked_byte_pattern_search: drives code byte images, checks scan results
// depends on mbps_pkg and the masked_byte_pattern_search rtl
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mbps_pkg::*;

   // run length and pacing
   localparam int RANDOM_WORDS   = 660;
   localparam int CYCLE_LIMIT    = 400000;  // far above the slowest legal run
   localparam int SETTLE_CYCLES  = 8;       // result shows in the cycle after tlast is taken, plus margin
   localparam int LONG_HOLD      = 300;     // receiver back-pressure stretch
   localparam int PRESSURE_PHASE = 3;

   // one code byte word as offered on req
   typedef struct {
      logic [BYTE_W-1:0] code_byte;
      logic              last_byte;
   } code_word_type;

   // one scan result as it should appear on rsp
   typedef struct packed {
      logic               found;
      logic [FIELD_W-1:0] match_position;
      logic [FIELD_W-1:0] patch_address;
   } scan_result_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   // block ports, all inputs known from time zero
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata  = '0;     // code_byte [7:0]
   logic                  req_tlast  = 1'b0;   // last byte of the image
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;           // match_position [23:0], patch_address [47:24]
   logic [0:0]            rsp_tuser;           // found [0]
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_W-1:0]      csr_data   = '0;

   masked_byte_pattern_search DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // words waiting to be offered and results waiting to come back
   code_word_type   code_words_pending [$];
   scan_result_type scan_results_due [$];

   // pacing controls set by the stimulus process
   logic sender_idle   = 1'b1;
   logic receiver_idle = 1'b1;
   logic receiver_hold = 1'b0;

   // bookkeeping
   int error_count     = 0;
   int words_queued    = 0;
   int words_accepted  = 0;
   int images_queued   = 0;
   int results_checked = 0;
   int setups_applied  = 0;
   int found_count     = 0;
   int cycle_count     = 0;

   // scanner's view of the configuration, tracks every accepted csr write
   logic [63:0]          pattern_low  = '0;
   logic [63:0]          pattern_high = '0;
   logic [15:0]          care_cfg     = 16'hFFFF;
   logic [LEN_RAW_W-1:0] pattern_len_cfg = 5'd1;
   logic [OFFSET_W-1:0]  patch_offset = '0;

   // scanner state: newest byte in cell 0
   logic [BYTE_W-1:0]       scan_window [PATTERN_BYTES];
   logic [ADDRESS_BITS-1:0] bytes_seen  = '0;
   logic                    match_seen  = 1'b0;
   logic [ADDRESS_BITS-1:0] first_start = '0;

   initial begin
      for (int i = 0; i < PATTERN_BYTES; i++) scan_window[i] = '0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // length register as the block uses it: zero acts as one, clipped at the window size
   function automatic int effective_length();
      int n;
      n = int'(pattern_len_cfg);
      if (n == 0) n = 1;
      if (n > PATTERN_BYTES) n = PATTERN_BYTES;
      return n;
   endfunction

   function automatic logic [BYTE_W-1:0] pattern_byte(input int k);
      logic [127:0] both;
      both = {pattern_high, pattern_low};
      return both[k*8 +: 8];
   endfunction

   // advance the scanner by one accepted byte; returns 1 when a result is due
   function automatic bit scan_code_byte(input logic [BYTE_W-1:0] b, input logic last_b,
                                         output scan_result_type res);
      int  len, i, k;
      bit  hit;
      res = '0;
      if (bytes_seen != {ADDRESS_BITS{1'b1}}) begin
         len = effective_length();
         for (i = PATTERN_BYTES - 1; i > 0; i--) scan_window[i] = scan_window[i-1];
         scan_window[0] = b;
         // pattern byte k sits len-1-k cells back from the newest byte
         hit = 1'b1;
         for (k = 0; k < len; k++) begin
            if (k < PATTERN_REG_BYTES && care_cfg[k] && scan_window[len-1-k] != pattern_byte(k))
               hit = 1'b0;
         end
         if (int'(bytes_seen) + 1 >= len && !match_seen && hit) begin
            match_seen  = 1'b1;
            first_start = ADDRESS_BITS'(int'(bytes_seen) + 1 - len);
         end
         bytes_seen = bytes_seen + ADDRESS_BITS'(1);
      end
      if (!last_b) return 1'b0;
      if (match_seen) begin
         res.found          = 1'b1;
         res.match_position = first_start;
         res.patch_address  = first_start + patch_offset;  // wraps at the address width
      end
      bytes_seen  = '0;
      match_seen  = 1'b0;
      first_start = '0;
      return 1'b1;
   endfunction

   // idle lengths: mostly none or short, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------------------------------
   // req driver: offers pending words, predicts on every accepted word
   // ---------------------------------------------------------------------------------------
   int req_gap = 0;

   always @(posedge clock) begin : drive_req
      code_word_type   nxt;
      scan_result_type res;
      bit              take;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         req_gap    <= 0;
      end else begin
         take = req_tvalid && req_tready;
         if (take) begin
            words_accepted++;
            if (scan_code_byte(req_tdata, req_tlast, res))
               scan_results_due = {scan_results_due, res};
         end
         // a held word stays put until taken; otherwise load the next one or idle
         if (take || !req_tvalid) begin
            if (req_gap != 0) begin
               req_tvalid <= 1'b0;
               req_gap    <= req_gap - 1;
            end else if (code_words_pending.size() != 0) begin
               nxt = code_words_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.code_byte;
               req_tlast  <= nxt.last_byte;
               req_gap    <= sender_idle ? idle_length() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // rsp monitor: compares each accepted result word with the oldest prediction
   // ---------------------------------------------------------------------------------------
   int rsp_stall = 0;

   always @(posedge clock) begin : watch_rsp
      scan_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (scan_results_due.size() == 0) begin
               report_mismatch($sformatf("result word with nothing due: found %b pos %h",
                                         rsp_tuser[0], rsp_tdata[FIELD_W-1:0]));
            end else begin
               want = scan_results_due.pop_front();
               if (want.found) found_count++;
               if (rsp_tuser[0] !== want.found)
                  report_mismatch($sformatf("found got %b expected %b",
                                            rsp_tuser[0], want.found));
               if (rsp_tdata[FIELD_W-1:0] !== want.match_position)
                  report_mismatch($sformatf("match_position got %h expected %h",
                                            rsp_tdata[FIELD_W-1:0], want.match_position));
               if (rsp_tdata[2*FIELD_W-1:FIELD_W] !== want.patch_address)
                  report_mismatch($sformatf("patch_address got %h expected %h",
                                            rsp_tdata[2*FIELD_W-1:FIELD_W],
                                            want.patch_address));
            end
         end
         // back-pressure: the long hold wins, then random stalls
         if (receiver_hold) begin
            rsp_tready <= 1'b0;
         end else if (rsp_stall != 0) begin
            rsp_tready <= 1'b0;
            rsp_stall  <= rsp_stall - 1;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall  <= receiver_idle ? idle_length() : 0;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------------------------------
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, scan_results_due.size());
      $display("FAIL masked_byte_pattern_search");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------------
   task automatic push_code_word(input logic [BYTE_W-1:0] b, input logic last_b);
      code_word_type w;
      w.code_byte = b;
      w.last_byte = last_b;
      code_words_pending = {code_words_pending, w};
      words_queued++;
   endtask

   // one csr write; the scanner takes the new value at the accepting edge
   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PATTERN_LOW:  pattern_low     = value;
         CSR_PATTERN_HIGH: pattern_high    = value;
         CSR_CARE_MASK:    care_cfg        = value[15:0];
         CSR_PATTERN_LEN:  pattern_len_cfg = value[LEN_RAW_W-1:0];
         CSR_PATCH_OFFSET: patch_offset    = value[OFFSET_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setup(input logic [63:0] low, input logic [63:0] high,
                              input logic [15:0] care, input logic [LEN_RAW_W-1:0] len,
                              input logic [OFFSET_W-1:0] offset);
      write_csr(CSR_PATTERN_LOW, low);
      write_csr(CSR_PATTERN_HIGH, high);
      write_csr(CSR_CARE_MASK, {48'd0, care});
      write_csr(CSR_PATTERN_LEN, {59'd0, len});
      write_csr(CSR_PATCH_OFFSET, {40'd0, offset});
      setups_applied++;
   endtask

   // drain: every word taken, every result back, then let the pipeline go quiet
   task automatic wait_idle();
      while (code_words_pending.size() != 0 || req_tvalid || scan_results_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // first phases pin the extremes, the rest are random
   task automatic random_setup(input int phase);
      logic [63:0]          low, high;
      logic [15:0]          care;
      logic [LEN_RAW_W-1:0] len;
      logic [OFFSET_W-1:0]  offset;
      int                   r;
      low    = {$urandom(), $urandom()};
      high   = {$urandom(), $urandom()};
      len    = LEN_RAW_W'($urandom_range(1, 16));
      offset = OFFSET_W'($urandom_range(0, 24'hFFFFFF));
      r      = $urandom_range(0, 9);
      care   = (r < 4) ? 16'hFFFF : (r < 5) ? 16'h0000 : 16'($urandom_range(0, 16'hFFFF));
      case (phase)
         0: begin
            len = 5'd16; care = 16'hFFFF; offset = 24'h7FFFFF;
         end
         1: begin
            len = 5'd31; care = 16'h0000; offset = 24'h800000;
         end
         2: begin
            len = 5'd0; offset = 24'hFFFFFF;
         end
         default: begin
            r = $urandom_range(0, 9);
            if (r == 0) len = 5'd0;
            else if (r == 1) len = LEN_RAW_W'($urandom_range(17, 31));
            else if (r == 2) len = 5'd16;
            r = $urandom_range(0, 9);
            if (r == 0) offset = 24'h7FFFFF;
            else if (r == 1) offset = 24'h800000;
            else if (r == 2) offset = '0;
         end
      endcase
      // low-entropy patterns make chance matches and near misses likely
      if ($urandom_range(0, 3) == 0) begin
         low  = low  & 64'h0101_0101_0101_0101;
         high = high & 64'h0101_0101_0101_0101;
      end
      apply_setup(low, high, care, len, offset);
   endtask

   // one image: noise mixed with pattern bytes, a few planted copies, maybe one broken
   task automatic queue_image(input int n, input int plants, input bit corrupt);
      logic [BYTE_W-1:0] img [$];
      int len, start, k, p, idx;
      len = effective_length();
      for (k = 0; k < n; k++)
         img = {img, ($urandom_range(0, 1) ? pattern_byte($urandom_range(0, 15))
                                           : BYTE_W'($urandom_range(0, 255)))};
      start = 0;
      for (p = 0; p < plants && n >= len; p++) begin
         start = $urandom_range(0, n - len);
         for (k = 0; k < len; k++)
            if (care_cfg[k]) img[start+k] = pattern_byte(k);
      end
      if (corrupt && n >= len) begin
         idx = start + $urandom_range(0, len - 1);
         img[idx] = img[idx] ^ BYTE_W'($urandom_range(1, 255));
      end
      for (k = 0; k < n; k++) push_code_word(img[k], k == n - 1);
      images_queued++;
   endtask

   function automatic int image_size();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(1, 24);
      if (r < 9) return $urandom_range(25, 48);
      return $urandom_range(49, 128);
   endfunction

   // ---------------------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      int phase, k, n_images, directed_words;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setup: single byte 0x00 pattern, all cared, zero offset
      push_code_word(8'h00, 1'b1);           // one-byte image that matches at 0
      push_code_word(8'hFF, 1'b0);
      push_code_word(8'hFF, 1'b0);
      push_code_word(8'h00, 1'b1);           // match on the marked last byte itself
      push_code_word(8'hFF, 1'b1);           // no match
      wait_idle();

      // four-byte pattern, offset of minus one
      apply_setup(64'h0000_0000_EFBE_ADDE, 64'h0, 16'hFFFF, 5'd4, 24'hFFFFFF);
      push_code_word(8'h11, 1'b0);           // pattern ends on the last byte: final start
      push_code_word(8'hDE, 1'b0);
      push_code_word(8'hAD, 1'b0);
      push_code_word(8'hBE, 1'b0);
      push_code_word(8'hEF, 1'b1);
      push_code_word(8'hDE, 1'b0);           // image shorter than the pattern
      push_code_word(8'hAD, 1'b1);
      push_code_word(8'hDE, 1'b0);           // match at 0, patch address wraps below zero
      push_code_word(8'hAD, 1'b0);
      push_code_word(8'hBE, 1'b0);
      push_code_word(8'hEF, 1'b1);
      wait_idle();

      // wildcard in position one, largest positive offset, all-ones upper pattern
      apply_setup(64'h0000_0000_EFBE_ADDE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFD, 5'd4, 24'h7FFFFF);
      push_code_word(8'hDE, 1'b0);           // first match wins over the later one
      push_code_word(8'h55, 1'b0);
      push_code_word(8'hBE, 1'b0);
      push_code_word(8'hEF, 1'b0);
      push_code_word(8'hDE, 1'b0);
      push_code_word(8'h00, 1'b0);
      push_code_word(8'hBE, 1'b0);
      push_code_word(8'hEF, 1'b1);
      directed_words = words_queued;

      // random phases: new setup, then a handful of images
      phase = 0;
      while (words_queued < directed_words + RANDOM_WORDS) begin
         wait_idle();
         random_setup(phase);
         // some phases run flat out on one or both sides
         sender_idle   <= ($urandom_range(0, 3) != 0);
         receiver_idle <= ($urandom_range(0, 3) != 0);
         if (phase == PRESSURE_PHASE) begin
            // many tiny images while rsp is held off, so the block backs up into req
            for (k = 0; k < 12; k++) queue_image($urandom_range(1, 4), 1, 1'b0);
            receiver_hold <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            receiver_hold <= 1'b0;
         end else begin
            n_images = $urandom_range(3, 8);
            for (k = 0; k < n_images; k++)
               queue_image(image_size(), $urandom_range(0, 2), $urandom_range(0, 4) == 0);
         end
         phase++;
      end
      wait_idle();

      $display("scanned %0d code bytes in %0d images across %0d register setups",
               words_accepted, images_queued, setups_applied);
      $display("checked %0d results (%0d with a match), %0d mismatches",
               results_checked, found_count, error_count);
      if (error_count == 0)
         $display("PASS masked_byte_pattern_search");
      else
         $display("FAIL masked_byte_pattern_search");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
sv/mbps_pkg.sv
sv/mbps_cell.sv
sv/mbps_window.sv
sv/masked_byte_pattern_search.sv
tb/tb_top.sv
